// ===== hdl/hbkd_pkg.sv =====
// Shared types, usage-code constants and key tables for the boot-keyboard decoder.
package hbkd_pkg;

  localparam logic [7:0] USAGE_LIMIT = 8'h68;
  localparam logic [7:0] USAGE_TAB   = 8'h2B;
  localparam logic [7:0] USAGE_RIGHT = 8'h4F;
  localparam logic [7:0] USAGE_UP    = 8'h52;
  localparam logic [7:0] USAGE_A     = 8'h04;
  localparam logic [7:0] USAGE_Z     = 8'h1D;
  localparam logic [7:0] MASK_SHIFT  = 8'h22;
  localparam logic [7:0] MASK_CTRL   = 8'h11;
  localparam logic [7:0] MASK_ALT    = 8'h44;
  localparam logic [7:0] ESC_BYTE    = 8'd27;
  localparam logic [7:0] CSI_BYTE    = 8'h5B;

  typedef enum logic [1:0] {
    EVT_WINDOW,
    EVT_ARROW,
    EVT_CHAR
  } evt_kind_t;

  // One lane's finding: whether the slot is a new press, what kind, and its byte.
  typedef struct packed {
    logic      active;
    evt_kind_t kind;
    logic [7:0] data;
  } lane_evt_t;

  // Final letter of the cursor sequence for the four arrow keys.
  function automatic logic [7:0] arrow_final(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = 8'h43;
      2'd1: ch = 8'h44;
      2'd2: ch = 8'h42;
      default: ch = 8'h41;
    endcase
    return ch;
  endfunction

  // Unshifted and shifted key tables; zero means the key gives no character.
  function automatic logic [7:0] key_char(input logic [7:0] code, input logic shift);
    logic [7:0] ch;
    ch = 8'h00;
    if (code >= USAGE_A && code <= USAGE_Z) begin
      ch = (shift ? 8'h41 : 8'h61) + (code - USAGE_A);
    end else begin
      case (code)
        8'h1E: ch = shift ? 8'h21 : 8'h31;
        8'h1F: ch = shift ? 8'h40 : 8'h32;
        8'h20: ch = shift ? 8'h23 : 8'h33;
        8'h21: ch = shift ? 8'h24 : 8'h34;
        8'h22: ch = shift ? 8'h25 : 8'h35;
        8'h23: ch = shift ? 8'h5E : 8'h36;
        8'h24: ch = shift ? 8'h26 : 8'h37;
        8'h25: ch = shift ? 8'h2A : 8'h38;
        8'h26: ch = shift ? 8'h28 : 8'h39;
        8'h27: ch = shift ? 8'h29 : 8'h30;
        8'h28: ch = 8'h0A;
        8'h29: ch = 8'h1B;
        8'h2A: ch = 8'h08;
        8'h2B: ch = 8'h09;
        8'h2C: ch = 8'h20;
        8'h2D: ch = shift ? 8'h5F : 8'h2D;
        8'h2E: ch = shift ? 8'h2B : 8'h3D;
        8'h2F: ch = shift ? 8'h7B : 8'h5B;
        8'h30: ch = shift ? 8'h7D : 8'h5D;
        8'h31: ch = shift ? 8'h7C : 8'h5C;
        8'h33: ch = shift ? 8'h3A : 8'h3B;
        8'h34: ch = shift ? 8'h22 : 8'h27;
        8'h35: ch = shift ? 8'h7E : 8'h60;
        8'h36: ch = shift ? 8'h3C : 8'h2C;
        8'h37: ch = shift ? 8'h3E : 8'h2E;
        8'h38: ch = shift ? 8'h3F : 8'h2F;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

// ===== hdl/hbkd_lane.sv =====
// One decode lane: tests a slot against the previous report and classifies the press.
module hbkd_lane import hbkd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic [7:0] code,
  input  logic [7:0] mods,
  input  logic [7:0] prev_keys [KEY_SLOTS],
  output lane_evt_t  evt
);

  logic       held;
  logic [7:0] ch;

  always_comb begin
    held = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (prev_keys[i] == code) held = 1'b1;
    end
  end

  assign ch = key_char(code, (mods & MASK_SHIFT) != 8'h00);

  always_comb begin
    evt.active = 1'b0;
    evt.kind   = EVT_CHAR;
    evt.data   = ch;
    if (code > 8'h01 && !held && code < USAGE_LIMIT) begin
      if ((mods & MASK_ALT) != 8'h00 && code == USAGE_TAB) begin
        evt.active = 1'b1;
        evt.kind   = EVT_WINDOW;
        evt.data   = 8'h00;
      end else if (code >= USAGE_RIGHT && code <= USAGE_UP) begin
        evt.active = 1'b1;
        evt.kind   = EVT_ARROW;
        evt.data   = arrow_final(2'(code - USAGE_RIGHT));
      end else if (ch != 8'h00) begin
        evt.active = 1'b1;
        // With Ctrl, a letter becomes its position in the alphabet.
        if ((mods & MASK_CTRL) != 8'h00 && code >= USAGE_A && code <= USAGE_Z) begin
          evt.data = code - 8'd3;
        end
      end
    end
  end

endmodule

// ===== hdl/hbkd_merge.sv =====
// Merging stage: walks the active lanes of one report in slot order, one byte per cycle while out_ready is high.
module hbkd_merge import hbkd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  output logic       load_ready,
  input  lane_evt_t  load_evt [KEY_SLOTS],
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_window,
  output logic       out_last
);

  logic [KEY_SLOTS-1:0] pending;
  logic [KEY_SLOTS-1:0] pick;
  logic [KEY_SLOTS-1:0] load_mask;
  lane_evt_t            evt [KEY_SLOTS];
  lane_evt_t            cur;
  logic [1:0]           sub;
  logic                 lane_done;
  logic                 xfer;

  assign pick = pending & (~pending + KEY_SLOTS'(1));

  always_comb begin
    cur = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (pick[i]) cur = cur | evt[i];
      load_mask[i] = load_evt[i].active;
    end
  end

  assign lane_done  = (cur.kind != EVT_ARROW) || (sub == 2'd2);
  assign out_valid  = |pending;
  assign out_last   = lane_done && ((pending & ~pick) == '0);
  assign out_window = (cur.kind == EVT_WINDOW);
  assign xfer       = out_valid && out_ready;
  assign load_ready = !out_valid || (xfer && out_last);

  always_comb begin
    case (cur.kind)
      EVT_WINDOW: out_byte = 8'h00;
      EVT_ARROW: begin
        case (sub)
          2'd0:    out_byte = ESC_BYTE;
          2'd1:    out_byte = CSI_BYTE;
          default: out_byte = cur.data;
        endcase
      end
      default: out_byte = cur.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      sub     <= 2'd0;
    end else if (load_valid && load_ready) begin
      pending <= load_mask;
      sub     <= 2'd0;
    end else if (xfer) begin
      if (lane_done) begin
        pending <= pending & ~pick;
        sub     <= 2'd0;
      end else begin
        sub <= sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      evt <= load_evt;
    end
  end

endmodule

// ===== hdl/hid_boot_keyboard_decoder_unit.sv =====
// Top level of the boot-keyboard report decoder: lanes, stage register and merge.
//
//  Channel  Direction  Handshake                     Payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata: modifier_bits, key_slot_0..5
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata: char_byte, tuser: window_switch,
//                                                    tlast: last_of_report
//
// A report is decoded by KEY_SLOTS parallel lanes in the cycle it is accepted and held in a
// stage register; the merge stage then sends one byte per cycle while m_axis_tready is high,
// so a report gives up to 18 bytes, all through the single output port.
// A report with no new press produces no output.
// The next report is accepted while the current one is still being sent.
// Reset is synchronous and clears the stored keys and all valid state.
module hid_boot_keyboard_decoder_unit import hbkd_pkg::*; #(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // modifier_bits, key_slot_0 .. key_slot_5
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // char_byte
  output logic        m_axis_tuser,  // window_switch
  output logic        m_axis_tlast   // last_of_report
);

  logic [7:0]           prev_keys [KEY_SLOTS];
  lane_evt_t            lane_evt  [KEY_SLOTS];
  lane_evt_t            stage_evt [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] lane_active;
  logic                 stage_valid;
  logic                 load_ready;
  logic                 in_xfer;

  assign s_axis_tready = !stage_valid || load_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hbkd_lane #(.KEY_SLOTS(KEY_SLOTS)) u_lane (
      .code      (s_axis_tdata[8*g+15 -: 8]),
      .mods      (s_axis_tdata[7:0]),
      .prev_keys (prev_keys),
      .evt       (lane_evt[g])
    );
    assign lane_active[g] = lane_evt[g].active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) prev_keys[i] <= 8'h00;
    end else begin
      if (in_xfer) begin
        // Reports without a new press never enter the merge stage.
        stage_valid <= |lane_active;
        for (int i = 0; i < KEY_SLOTS; i++) prev_keys[i] <= s_axis_tdata[8*i+8 +: 8];
      end else if (load_ready) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_evt <= lane_evt;
    end
  end

  hbkd_merge #(.KEY_SLOTS(KEY_SLOTS)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stage_valid),
    .load_ready (load_ready),
    .load_evt   (stage_evt),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_window (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule
